// ===== hw/rtl/cossim_pkg.sv =====
// Package for the streaming Q1.15 cosine similarity block.
// Holds accumulator widths, saturation limits and the front-to-back record type.
package cossim_pkg;

  localparam int AccW = 48;
  localparam int SumW = 47;
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [SumW-1:0] NormMax = {SumW{1'b1}};
  localparam int QueueDepth = 2;

  // Widths of the root search: na*nb, dot^2 and dot^2 * 2^30.
  localparam int ProdW = 2 * SumW;
  localparam int SqW = 2 * AccW;
  localparam int RhsShift = 30;
  localparam int LhsW = SqW + RhsShift;
  localparam int RootW = 16;

  // Finished sums handed from the accumulator to the divider.
  typedef struct packed {
    logic signed [AccW-1:0] dot;
    logic [SumW-1:0]        norm_a;
    logic [SumW-1:0]        norm_b;
  } sums_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SUM,
    ST_TEST,
    ST_DONE
  } div_state_t;

endpackage

// ===== hw/rtl/cosine_similarity_q15.sv =====
// Top level of the streaming Q1.15 cosine similarity block.
// Instantiates cossim_front, cossim_queue and cossim_back; uses cossim_pkg.
//
//  channel | handshake            | fields                          | role
//  in      | in_valid, in_stall   | a_value, b_value, last_element  | sink
//  out     | out_valid, out_stall | similarity, zero_norm           | source
//
// One element pair per cycle into the accumulator, items back to back, while
// in_stall is low. The back part loads a vector, forms 8 multiply pieces, then
// finds 16 root bits, each in a sum and a test step, and ends in an output
// state held while out_stall is high; when a norm is zero it goes from load
// straight to output. A two-entry queue lets the next vectors accumulate meanwhile.
// Reset clears accumulators, queue and the search sequencer.
// in_stall rises only on a last item while the queue is full.
module cosine_similarity_q15 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] a_value,
  input  logic signed [15:0] b_value,
  input  logic               last_element,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] similarity,
  output logic               zero_norm
);
  import cossim_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic not_empty;
  sums_t push_data;
  sums_t pop_data;

  cossim_front u_front (
    .clk, .rst, .in_valid, .in_stall, .a_value, .b_value, .last_element,
    .push, .push_data, .queue_full(full)
  );

  cossim_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .not_empty, .pop_data
  );

  cossim_back u_back (
    .clk, .rst, .not_empty, .pop_data, .pop, .out_valid, .out_stall,
    .similarity, .zero_norm
  );
endmodule

// ===== hw/rtl/cossim_front.sv =====
// Front part: one multiply-accumulate per item with saturating sums.
// Pushes finished sums into the queue on the last item. Uses cossim_pkg.
module cossim_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [15:0]     a_value,
  input  logic signed [15:0]     b_value,
  input  logic                   last_element,
  output logic                   push,
  output cossim_pkg::sums_t      push_data,
  input  logic                   queue_full
);
  import cossim_pkg::*;

  logic signed [AccW-1:0] dot;
  logic [SumW-1:0] norm_a;
  logic [SumW-1:0] norm_b;
  logic signed [AccW-1:0] dot_next;
  logic [SumW-1:0] norm_a_next;
  logic [SumW-1:0] norm_b_next;
  logic signed [31:0] pab;
  logic [31:0] paa;
  logic [31:0] pbb;
  logic signed [AccW:0] dsum;
  logic [SumW:0] asum;
  logic [SumW:0] bsum;
  logic acc;

  assign in_stall = last_element & queue_full;
  assign acc = in_valid & ~in_stall;

  always_comb begin
    pab = 32'(a_value) * 32'(b_value);
    paa = 32'(a_value) * 32'(a_value);
    pbb = 32'(b_value) * 32'(b_value);
    dsum = {dot[AccW-1], dot} + (AccW+1)'(pab);
    asum = {1'b0, norm_a} + (SumW+1)'(paa);
    bsum = {1'b0, norm_b} + (SumW+1)'(pbb);
    if (dsum > (AccW+1)'(AccMax)) dot_next = AccMax;
    else if (dsum < (AccW+1)'(AccMin)) dot_next = AccMin;
    else dot_next = dsum[AccW-1:0];
    norm_a_next = asum[SumW] ? NormMax : asum[SumW-1:0];
    norm_b_next = bsum[SumW] ? NormMax : bsum[SumW-1:0];
  end

  assign push = acc & last_element;
  assign push_data = '{dot: dot_next, norm_a: norm_a_next, norm_b: norm_b_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      dot <= '0;
      norm_a <= '0;
      norm_b <= '0;
    end else if (acc) begin
      if (last_element) begin
        dot <= '0;
        norm_a <= '0;
        norm_b <= '0;
      end else begin
        dot <= dot_next;
        norm_a <= norm_a_next;
        norm_b <= norm_b_next;
      end
    end
  end
endmodule

// ===== hw/rtl/cossim_queue.sv =====
// Short FIFO of finished sums between front and back parts.
// Depth from cossim_pkg::QueueDepth.
module cossim_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cossim_pkg::sums_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output cossim_pkg::sums_t pop_data
);
  import cossim_pkg::*;
  localparam int PtrW = $clog2(QueueDepth);

  sums_t mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0] count;

  assign full = (count == (PtrW+1)'(QueueDepth));
  assign not_empty = (count != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(QueueDepth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PtrW'(QueueDepth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// ===== hw/rtl/cossim_back.sv =====
// Back part: forms na*nb and dot^2 from 32x32 pieces, one per cycle, then
// searches bit by bit for the largest m with m^2*na*nb <= dot^2*2^30. Uses cossim_pkg.
module cossim_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  cossim_pkg::sums_t pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [15:0] similarity,
  output logic              zero_norm
);
  import cossim_pkg::*;

  div_state_t state;
  div_state_t state_next;
  logic neg;
  logic zn;
  logic load_zero;
  logic [AccW-1:0] mag;
  logic [SumW-1:0] na;
  logic [SumW-1:0] nb;
  logic [2:0] part;
  logic [AccW-1:0] op_x;
  logic [AccW-1:0] op_y;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] pp;
  logic [SqW-1:0] piece;
  logic [ProdW-1:0] nprod;
  logic [SqW-1:0] msq;
  logic [LhsW-1:0] rhs;
  logic [LhsW-1:0] sk;
  logic [LhsW-1:0] q;
  logic [LhsW-1:0] m2p;
  logic [LhsW-1:0] t;
  logic [RootW-1:0] m;
  logic [RootW-1:0] cand;
  logic [RootW-1:0] m_final;
  logic [3:0] bitpos;
  logic cap_ok;
  logic take;
  logic [RootW-1:0] res;

  assign similarity = res;
  assign zero_norm = zn;
  assign load_zero = (pop_data.norm_a == '0) | (pop_data.norm_b == '0);
  assign rhs = {msq, {RhsShift{1'b0}}};

  // piece order: lo*lo, hi*lo, lo*hi, hi*hi; na*nb first, then mag*mag
  always_comb begin
    op_x = part[2] ? mag : {1'b0, na};
    op_y = part[2] ? mag : {1'b0, nb};
    mul_a = part[0] ? {16'd0, op_x[AccW-1:32]} : op_x[31:0];
    mul_b = part[1] ? {16'd0, op_y[AccW-1:32]} : op_y[31:0];
    pp = 64'(mul_a) * 64'(mul_b);
    unique case (part[1:0])
      2'd0: piece = SqW'(pp);
      2'd1, 2'd2: piece = SqW'(pp) << 32;
      default: piece = SqW'(pp) << 64;
    endcase
  end

  // t holds (m | bit)^2 * na*nb; a negative dot may reach 32768
  always_comb begin
    cand = m | (16'd1 << bitpos);
    cap_ok = neg ? (!cand[15] || (cand[14:0] == '0)) : !cand[15];
    take = (t <= rhs) && cap_ok;
    m_final = take ? cand : m;
  end

  always_comb begin
    state_next = state;
    pop = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        pop = not_empty;
        if (not_empty) state_next = load_zero ? ST_DONE : ST_PROD;
      end
      ST_PROD: if (part == 3'd7) state_next = ST_SUM;
      ST_SUM: state_next = ST_TEST;
      ST_TEST: state_next = (bitpos == '0) ? ST_DONE : ST_SUM;
      ST_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (not_empty) begin
          neg <= pop_data.dot[AccW-1];
          mag <= pop_data.dot[AccW-1] ? -pop_data.dot : pop_data.dot;
          na <= pop_data.norm_a;
          nb <= pop_data.norm_b;
          zn <= load_zero;
          res <= '0;
          nprod <= '0;
          msq <= '0;
          part <= '0;
        end
      end
      ST_PROD: begin
        if (part[2]) msq <= msq + piece;
        else nprod <= nprod + piece[ProdW-1:0];
        part <= part + 3'd1;
        // start the search at the top bit with m = 0
        if (part == 3'd7) begin
          sk <= LhsW'(nprod) << (2 * (RootW - 1));
          q <= '0;
          m2p <= '0;
          m <= '0;
          bitpos <= 4'd15;
        end
      end
      ST_SUM: t <= m2p + q + sk;
      ST_TEST: begin
        // q tracks m*na*nb*2^(bit+1), sk tracks na*nb*2^(2*bit)
        if (take) m2p <= t;
        q <= (q >> 1) + (take ? sk : '0);
        sk <= sk >> 2;
        m <= m_final;
        bitpos <= bitpos - 4'd1;
        res <= neg ? 16'(-m_final) : m_final;
      end
      default: ;
    endcase
  end
endmodule

// ===== sim/tb_cosine_similarity_q15.sv =====
`timescale 1ns / 100ps
// Testbench for cosine_similarity_q15: streams element pairs, predicts the
// similarity of each vector and checks every result in order. Needs the RTL only.
module tb_cosine_similarity_q15;

  localparam logic signed [47:0] DotMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] DotMin = -48'sh7FFF_FFFF_FFFF - 48'sd1;
  localparam logic [47:0] NormLimit = 48'h7FFF_FFFF_FFFF;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               last;
    logic               known;
    logic signed [15:0] sim;
    logic               zero;
  } pair_row_t;

  typedef struct {
    logic signed [15:0] sim;
    logic               zero;
  } sim_result_t;

  logic clk, rst;
  logic in_valid, in_stall, last_element;
  logic signed [15:0] a_value, b_value;
  logic out_valid, out_stall, zero_norm;
  logic signed [15:0] similarity;

  logic signed [47:0] dot_acc;
  logic [47:0] norm_a_acc, norm_b_acc;
  sim_result_t expected_q[$];
  int errors, vectors_seen, results_seen;
  int send_idle_pct, recv_idle_pct;
  pair_row_t directed[$];

  cosine_similarity_q15 DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_cosine_similarity_q15 NOT OK");
    $finish;
  end

  // Largest m with m^2*na*nb <= dot^2*2^30, signed by dot and capped.
  function automatic logic signed [15:0] cosine_of(logic signed [47:0] d,
                                                   logic [47:0] na, logic [47:0] nb);
    logic [47:0] mag;
    logic [255:0] rhs, lhs;
    logic [16:0] lo, hi, mid;
    mag = d < 0 ? -d : d;
    rhs = ({208'd0, mag} * mag) << 30;
    lo = 0;
    hi = d < 0 ? 17'd32768 : 17'd32767;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = {239'd0, mid} * mid * na * nb;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return d < 0 ? -$signed(lo[15:0]) : lo[15:0];
  endfunction

  // Accumulate one pair; on a last item queue the expected similarity and clear.
  task automatic accumulate_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    logic signed [63:0] d;
    logic [63:0] s;
    sim_result_t r;
    d = 64'(dot_acc) + 64'(a) * 64'(b);
    if (d > 64'(DotMax)) d = 64'(DotMax);
    if (d < 64'(DotMin)) d = 64'(DotMin);
    dot_acc = d[47:0];
    s = 64'(norm_a_acc) + 64'(a) * 64'(a);
    norm_a_acc = s > 64'(NormLimit) ? NormLimit : s[47:0];
    s = 64'(norm_b_acc) + 64'(b) * 64'(b);
    norm_b_acc = s > 64'(NormLimit) ? NormLimit : s[47:0];
    if (last) begin
      r.zero = (norm_a_acc == 0) || (norm_b_acc == 0);
      r.sim = r.zero ? 16'sd0 : cosine_of(dot_acc, norm_a_acc, norm_b_acc);
      expected_q.insert(expected_q.size(), r);
      vectors_seen++;
      dot_acc = 0;
      norm_a_acc = 0;
      norm_b_acc = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: mismatch %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Send one item; hold it until accepted.
  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    a_value <= a;
    b_value <= b;
    last_element <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accumulate_pair(a, b, last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", similarity, 0);
        end else begin
          if (similarity !== expected_q[0].sim)
            report_mismatch("similarity", similarity, expected_q[0].sim);
          if (zero_norm !== expected_q[0].zero)
            report_mismatch("zero_norm", zero_norm, expected_q[0].zero);
          void'(expected_q.pop_front());
        end
      end
    end
  end

  function automatic pair_row_t row(int a, int b, bit last, bit known = 0,
                                    int sim = 0, bit zero = 0);
    pair_row_t r;
    r.a = a; r.b = b; r.last = last; r.known = known; r.sim = sim; r.zero = zero;
    return r;
  endfunction

  function automatic void add_row(pair_row_t r);
    directed.insert(directed.size(), r);
  endfunction

  // Random element: mostly full range, some near extremes or zero.
  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(9))
      0: return 16'(16'sh8000 + $urandom_range(3));
      1: return 16'(16'sh7FFF - $urandom_range(3));
      2: return 0;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int len, cnt, rest;
    logic signed [15:0] av, bv;
    errors = 0; vectors_seen = 0; results_seen = 0;
    send_idle_pct = 36; recv_idle_pct = 83;
    dot_acc = 0; norm_a_acc = 0; norm_b_acc = 0;
    rst = 1; in_valid = 0; a_value = 0; b_value = 0; last_element = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_row(row(0, 0, 1, 1, 0, 1));              // both norms zero
    add_row(row(16384, 0, 1, 1, 0, 1));          // one norm zero
    add_row(row(0, -5, 1, 1, 0, 1));
    add_row(row(32767, 32767, 1, 1, 32767, 0));  // identical
    add_row(row(-32768, -32768, 1, 1, 32767, 0));
    add_row(row(-32768, 32767, 1, 1, -32768, 0)); // opposite
    add_row(row(1, -1, 1, 1, -32768, 0));
    add_row(row(100, 0, 0));                     // orthogonal pair
    add_row(row(0, 100, 1, 1, 0, 0));
    add_row(row(3, 4, 0));
    add_row(row(-7, 2, 0));
    add_row(row(12000, -9000, 1));
    add_row(row(-1, -32768, 0));
    add_row(row(32767, 1, 1));
    foreach (directed[i]) begin
      send_pair(directed[i].a, directed[i].b, directed[i].last);
      if (directed[i].known) begin
        if (expected_q[$].sim !== directed[i].sim || expected_q[$].zero !== directed[i].zero)
          report_mismatch("directed row prediction", expected_q[$].sim, directed[i].sim);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 83; recv_idle_pct = 36; end
      if (phase == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      cnt = 0;
      while (cnt < 200) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
        rest = $urandom_range(3);
        for (int i = 0; i < len; i++) begin
          av = rand_elem();
          // correlate b with a in some vectors to spread the result range
          case (rest)
            0: bv = av;
            1: bv = -av;
            default: bv = rand_elem();
          endcase
          send_pair(av, bv, i == len - 1);
          cnt++;
        end
      end
    end

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d vectors, %0d results checked, incl. zero norms and extremes",
             vectors_seen, results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_cosine_similarity_q15 OK");
    end else begin
      $display("tb_cosine_similarity_q15 NOT OK");
    end
    $finish;
  end

endmodule
